// ===== hdl/gddo_pkg.sv =====
`timescale 1ns / 1ps

package gddo_pkg;

    // Calendar limits.
    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam logic [13:0] YEAR_MIN      = 14'd0;
    localparam logic [13:0] LEAP_CYCLE    = 14'd400;
    localparam logic [8:0]  LEAP_CYC_LAST = 9'd399;
    localparam logic [8:0]  CENTURY_1     = 9'd100;
    localparam logic [8:0]  CENTURY_2     = 9'd200;
    localparam logic [8:0]  CENTURY_3     = 9'd300;

    // Month numbers.
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // Month lengths.
    localparam logic [4:0] LEN_LONG     = 5'd31;
    localparam logic [4:0] LEN_SHORT    = 5'd30;
    localparam logic [4:0] LEN_FEB_LEAP = 5'd29;
    localparam logic [4:0] LEN_FEB      = 5'd28;

    // Operation codes.
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic reduce;
        logic check;
        logic walk;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reduce_done;
        logic walk_done;
    } t_dp_sts;

    // Leap test on the year taken modulo 400.
    function automatic logic f_is_leap(input logic [8:0] ymod);
        logic century;
        century = (ymod == CENTURY_1) || (ymod == CENTURY_2) || (ymod == CENTURY_3);
        return (ymod[1:0] == 2'b00) && !century;
    endfunction

    // Length of a month; codes outside 1..12 read as a long month.
    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
            MON_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/gddo_ctrl.sv =====
`timescale 1ns / 1ps

module gddo_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  gddo_pkg::t_dp_sts  i_sts,
    output gddo_pkg::t_dp_cmd  o_cmd,
    output logic               busy,
    output logic               o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_done;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_REDUCE;
            S_REDUCE: if (i_sts.reduce_done) n_state = S_CHECK;
            S_CHECK:  n_state = S_WALK;
            S_WALK:   if (i_sts.walk_done) n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath commands follow the current state.
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && start;
        o_cmd.reduce = (r_state == S_REDUCE);
        o_cmd.check  = (r_state == S_CHECK);
        o_cmd.walk   = (r_state == S_WALK);
        o_cmd.finish = (r_state == S_FINISH);
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (r_state == S_FINISH);
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

endmodule

// ===== hdl/gddo_datapath.sv =====
`timescale 1ns / 1ps

module gddo_datapath #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                   i_clk,
    input  gddo_pkg::t_dp_cmd      i_cmd,
    output gddo_pkg::t_dp_sts      o_sts,
    input  logic                   i_operation,
    input  logic [4:0]             i_day_in,
    input  logic [3:0]             i_month_in,
    input  logic [13:0]            i_year_in,
    input  logic [OFFSET_BITS-1:0] i_offset_days,
    output logic [4:0]             o_day_out,
    output logic [3:0]             o_month_out,
    output logic [13:0]            o_year_out,
    output logic                   o_input_correct,
    output logic                   o_out_of_range
);

    // Day count width: offset plus a day, plus a sign bit.
    localparam int DW = OFFSET_BITS + 2;

    logic                   r_op;
    logic [4:0]             r_day;
    logic [3:0]             r_mon_in;
    logic [13:0]            r_year_in;
    logic [OFFSET_BITS-1:0] r_off;
    logic signed [DW-1:0]   r_d;
    logic [3:0]             r_m;
    logic [13:0]            r_y;
    logic [13:0]            r_ymod;
    logic                   r_bad;
    logic                   r_okin;
    logic [4:0]             r_day_out;
    logic [3:0]             r_month_out;
    logic [13:0]            r_year_out;
    logic                   r_correct_out;
    logic                   r_range_out;

    logic                   w_leap_cur;
    logic [4:0]             w_len_cur;
    logic signed [DW-1:0]   w_len_cur_s;
    logic [3:0]             w_m_dn;
    logic [8:0]             w_ymod_dn;
    logic [8:0]             w_ymod_sel;
    logic [4:0]             w_len_dn;
    logic signed [DW-1:0]   w_day_s;
    logic signed [DW-1:0]   w_off_s;
    logic [8:0]             w_ymod_up;
    logic                   w_mon_ok;
    logic                   w_walk_done;

    // Length of the month the walk stands in.
    assign w_leap_cur  = gddo_pkg::f_is_leap(r_ymod[8:0]);
    assign w_len_cur   = gddo_pkg::f_month_len(r_m, w_leap_cur);
    assign w_len_cur_s = $signed({{(DW-5){1'b0}}, w_len_cur});

    // Backward step: the previous month and its length.
    assign w_m_dn     = (r_m == gddo_pkg::MON_JAN) ? gddo_pkg::MON_DEC : r_m - 4'd1;
    assign w_ymod_dn  = (r_ymod[8:0] == 9'd0) ? gddo_pkg::LEAP_CYC_LAST : r_ymod[8:0] - 9'd1;
    assign w_ymod_sel = (r_m == gddo_pkg::MON_JAN) ? w_ymod_dn : r_ymod[8:0];
    assign w_len_dn   = gddo_pkg::f_month_len(w_m_dn, gddo_pkg::f_is_leap(w_ymod_sel));

    // Forward step: year modulo 400 after a new year.
    assign w_ymod_up = (r_ymod[8:0] == gddo_pkg::LEAP_CYC_LAST) ? 9'd0 : r_ymod[8:0] + 9'd1;

    // Starting day count operands.
    assign w_day_s = $signed({{(DW-5){1'b0}}, r_day});
    assign w_off_s = $signed({2'b00, r_off});

    assign w_mon_ok = (r_mon_in >= gddo_pkg::MON_JAN) && (r_mon_in <= gddo_pkg::MON_DEC);

    // The walk ends once the day is within the month end (forward) or positive (backward), or on an error.
    assign w_walk_done = r_bad ||
        ((r_op == gddo_pkg::OP_ADD) ? (r_d <= w_len_cur_s) : (r_d > $signed({DW{1'b0}})));

    assign o_sts.reduce_done = (r_ymod < gddo_pkg::LEAP_CYCLE);
    assign o_sts.walk_done   = w_walk_done;

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_day     <= i_day_in;
            r_mon_in  <= i_month_in;
            r_year_in <= i_year_in;
            r_off     <= i_offset_days;
            r_ymod    <= i_year_in;
        end else if (i_cmd.reduce) begin
            // Reduce the year modulo 400, one subtraction per cycle.
            if (r_ymod >= gddo_pkg::LEAP_CYCLE) begin
                r_ymod <= r_ymod - gddo_pkg::LEAP_CYCLE;
            end
        end else if (i_cmd.check) begin
            r_okin <= w_mon_ok && (r_day != 5'd0) &&
                      (r_day <= gddo_pkg::f_month_len(r_mon_in, w_leap_cur));
            r_bad  <= !w_mon_ok || (r_year_in > gddo_pkg::YEAR_MAX);
            r_m    <= r_mon_in;
            r_y    <= r_year_in;
            r_d    <= (r_op == gddo_pkg::OP_SUB) ? w_day_s - w_off_s : w_day_s + w_off_s;
        end else if (i_cmd.walk && !w_walk_done) begin
            if (r_op == gddo_pkg::OP_ADD) begin
                // Leave the current month forward.
                r_d <= r_d - w_len_cur_s;
                if (r_m == gddo_pkg::MON_DEC) begin
                    r_m    <= gddo_pkg::MON_JAN;
                    r_y    <= r_y + 14'd1;
                    r_ymod <= {5'd0, w_ymod_up};
                    if (r_y == gddo_pkg::YEAR_MAX) begin
                        r_bad <= 1'b1;
                    end
                end else begin
                    r_m <= r_m + 4'd1;
                end
            end else begin
                // Step back into the previous month.
                if ((r_m == gddo_pkg::MON_JAN) && (r_y == gddo_pkg::YEAR_MIN)) begin
                    r_bad <= 1'b1;
                end else begin
                    r_m    <= w_m_dn;
                    r_ymod <= {5'd0, w_ymod_sel};
                    r_d    <= r_d + $signed({{(DW-5){1'b0}}, w_len_dn});
                    if (r_m == gddo_pkg::MON_JAN) begin
                        r_y <= r_y - 14'd1;
                    end
                end
            end
        end
    end

    // Result registers; an error returns the starting date.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_day_out     <= r_bad ? r_day : r_d[4:0];
            r_month_out   <= r_bad ? r_mon_in : r_m;
            r_year_out    <= r_bad ? r_year_in : r_y;
            r_correct_out <= r_okin;
            r_range_out   <= r_bad;
        end
    end

    assign o_day_out       = r_day_out;
    assign o_month_out     = r_month_out;
    assign o_year_out      = r_year_out;
    assign o_input_correct = r_correct_out;
    assign o_out_of_range  = r_range_out;

endmodule

// ===== hdl/gregorian_date_day_offset_core.sv =====
`timescale 1ns / 1ps

// Moves a Gregorian date forward or back by a day count and flags an input
// date that does not exist and a month, input year or result year out of range.
// An item is taken when start is high and busy is low; its result appears
// for exactly one cycle with o_done high, and the receiver cannot stall it.
// After acceptance the block reduces the year modulo 400 for the leap rule,
// one subtraction of 400 per cycle (at most 40 subtractions), checks the
// input, walks the months, one per cycle (about 2200 months for an offset of
// 65535 days), and registers the result. busy falls in the cycle o_done is
// shown, so the next item can be taken then.
module gregorian_date_day_offset_core #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_operation,
    input  logic [4:0]             i_day_in,
    input  logic [3:0]             i_month_in,
    input  logic [13:0]            i_year_in,
    input  logic [OFFSET_BITS-1:0] i_offset_days,
    output logic                   o_done,
    output logic [4:0]             o_day_out,
    output logic [3:0]             o_month_out,
    output logic [13:0]            o_year_out,
    output logic                   o_input_correct,
    output logic                   o_out_of_range
);

    gddo_pkg::t_dp_cmd w_cmd;
    gddo_pkg::t_dp_sts w_sts;

    // Sequencer.
    gddo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // Date arithmetic.
    gddo_datapath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_operation     (i_operation),
        .i_day_in        (i_day_in),
        .i_month_in      (i_month_in),
        .i_year_in       (i_year_in),
        .i_offset_days   (i_offset_days),
        .o_day_out       (o_day_out),
        .o_month_out     (o_month_out),
        .o_year_out      (o_year_out),
        .o_input_correct (o_input_correct),
        .o_out_of_range  (o_out_of_range)
    );

    // A result is shown while the block is already free again.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // Each item gives a single one-cycle result.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // A month outside 1..12 is always reported as out of range.
    a_bad_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_month_out == 4'd0) || (o_month_out > 4'd12))) |-> o_out_of_range)
        else $error("invalid month not flagged");

endmodule

// ===== test/gregorian_date_day_offset_core_test.sv =====
`timescale 1ns / 1ps

module gregorian_date_day_offset_core_test;

    localparam int OFF_W        = 16;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 250;
    localparam int SETTLE_TIME  = 60;

    // One moved date as the block reports it.
    typedef struct {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        correct;
        logic        range_err;
    } t_moved_date;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_operation;
    logic [4:0]       i_day_in;
    logic [3:0]       i_month_in;
    logic [13:0]      i_year_in;
    logic [OFF_W-1:0] i_offset_days;
    logic             o_done;
    logic [4:0]       o_day_out;
    logic [3:0]       o_month_out;
    logic [13:0]      o_year_out;
    logic             o_input_correct;
    logic             o_out_of_range;

    t_moved_date pending_dates[$];
    int          mismatch_count;
    int          idle_cycles;

    gregorian_date_day_offset_core #(
        .OFFSET_BITS(OFF_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_day_in       (i_day_in),
        .i_month_in     (i_month_in),
        .i_year_in      (i_year_in),
        .i_offset_days  (i_offset_days),
        .o_done         (o_done),
        .o_day_out      (o_day_out),
        .o_month_out    (o_month_out),
        .o_year_out     (o_year_out),
        .o_input_correct(o_input_correct),
        .o_out_of_range (o_out_of_range)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Number of days in month m of year y, with the Gregorian leap rule.
    function automatic int month_days(input int m, input int y);
        bit leap;
        leap = (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
        case (m)
            int'(gddo_pkg::MON_APR), int'(gddo_pkg::MON_JUN),
            int'(gddo_pkg::MON_SEP), int'(gddo_pkg::MON_NOV):
                return int'(gddo_pkg::LEN_SHORT);
            int'(gddo_pkg::MON_FEB):
                return leap ? int'(gddo_pkg::LEN_FEB_LEAP) : int'(gddo_pkg::LEN_FEB);
            default:
                return int'(gddo_pkg::LEN_LONG);
        endcase
    endfunction

    // Expected result of moving a date by a number of days.
    function automatic t_moved_date shift_date(input logic op, input logic [4:0] day_in,
                                               input logic [3:0] mon_in,
                                               input logic [13:0] year_in,
                                               input logic [OFF_W-1:0] offset);
        t_moved_date res;
        int d;
        int m;
        int y;
        bit bad;
        d = int'(day_in);
        m = int'(mon_in);
        y = int'(year_in);
        bad = 1'b0;
        res.correct = 1'b0;
        if (m < int'(gddo_pkg::MON_JAN) || m > int'(gddo_pkg::MON_DEC)) begin
            bad = 1'b1;
        end else begin
            res.correct = (d >= 1) && (d <= month_days(m, y));
            if (y > int'(gddo_pkg::YEAR_MAX)) begin
                bad = 1'b1;
            end else if (op == gddo_pkg::OP_ADD) begin
                // Forward walk: strip whole months off the day count.
                d = d + int'(offset);
                while (d > month_days(m, y)) begin
                    d -= month_days(m, y);
                    m++;
                    if (m > int'(gddo_pkg::MON_DEC)) begin
                        m = int'(gddo_pkg::MON_JAN);
                        y++;
                        if (y > int'(gddo_pkg::YEAR_MAX)) begin
                            bad = 1'b1;
                            break;
                        end
                    end
                end
            end else begin
                // Backward walk: borrow the previous month until the day is positive.
                d = d - int'(offset);
                while (d <= 0) begin
                    m--;
                    if (m < int'(gddo_pkg::MON_JAN)) begin
                        m = int'(gddo_pkg::MON_DEC);
                        y--;
                        if (y < int'(gddo_pkg::YEAR_MIN)) begin
                            bad = 1'b1;
                            break;
                        end
                    end
                    d += month_days(m, y);
                end
            end
        end
        // A date that cannot be moved comes back as it went in.
        if (bad) begin
            d = int'(day_in);
            m = int'(mon_in);
            y = int'(year_in);
        end
        res.day       = d[4:0];
        res.month     = m[3:0];
        res.year      = y[13:0];
        res.range_err = bad;
        return res;
    endfunction

    // Report one mismatch; only the first few are printed.
    function automatic void note_mismatch(input string what, input int exp_val,
                                          input int act_val);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what,
                     exp_val, act_val);
        end
    endfunction

    // Compare each result with the oldest outstanding date.
    always @(posedge i_clk) begin
        t_moved_date exp_date;
        if (i_rst_n && o_done) begin
            if (pending_dates.size() == 0) begin
                note_mismatch("unexpected result (day)", -1, int'(o_day_out));
            end else begin
                exp_date = pending_dates.pop_front();
                if (o_day_out !== exp_date.day)
                    note_mismatch("day", int'(exp_date.day), int'(o_day_out));
                if (o_month_out !== exp_date.month)
                    note_mismatch("month", int'(exp_date.month), int'(o_month_out));
                if (o_year_out !== exp_date.year)
                    note_mismatch("year", int'(exp_date.year), int'(o_year_out));
                if (o_input_correct !== exp_date.correct)
                    note_mismatch("input_correct", int'(exp_date.correct),
                                  int'(o_input_correct));
                if (o_out_of_range !== exp_date.range_err)
                    note_mismatch("out_of_range", int'(exp_date.range_err),
                                  int'(o_out_of_range));
            end
        end
    end

    // Count cycles in which neither an item nor a result moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        idle_cycles = 0;
        wait (idle_cycles >= IDLE_LIMIT);
        $display("[%0t] no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("gregorian_date_day_offset_core_test failed");
        $finish;
    end

    // Present one item and hold it until the block takes it.
    task automatic send_item(input logic op, input logic [4:0] day_in,
                             input logic [3:0] mon_in, input logic [13:0] year_in,
                             input logic [OFF_W-1:0] offset);
        @(negedge i_clk);
        start         <= 1'b1;
        i_operation   <= op;
        i_day_in      <= day_in;
        i_month_in    <= mon_in;
        i_year_in     <= year_in;
        i_offset_days <= offset;
        while (busy) @(negedge i_clk);
        // busy is low before this edge, so the item is taken on it.
        pending_dates.push_back(shift_date(op, day_in, mon_in, year_in, offset));
        @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_dates.size() != 0) @(negedge i_clk);
    endtask

    // Plain moves at the edges of the offset range.
    task automatic test_offset_extremes();
        send_item(gddo_pkg::OP_ADD, 5'd1, gddo_pkg::MON_JAN, 14'd0, '0);
        send_item(gddo_pkg::OP_SUB, 5'd1, gddo_pkg::MON_JAN, 14'd0, '0);
        send_item(gddo_pkg::OP_ADD, 5'd15, 4'd6, 14'd5000, '1);
        send_item(gddo_pkg::OP_SUB, 5'd15, 4'd6, 14'd5000, '1);
        send_item(gddo_pkg::OP_ADD, 5'd1, gddo_pkg::MON_JAN, 14'd0, '1);
        send_item(gddo_pkg::OP_SUB, 5'd31, gddo_pkg::MON_DEC, 14'd9999, '1);
    endtask

    // Month codes outside 1..12, years beyond the calendar and walks that run off its ends.
    task automatic test_range_errors();
        send_item(gddo_pkg::OP_ADD, 5'd10, 4'd0, 14'd2000, 16'd5);
        send_item(gddo_pkg::OP_SUB, 5'd31, 4'd13, 14'd16383, 16'd5);
        send_item(gddo_pkg::OP_ADD, 5'd0, 4'd15, 14'd0, '1);
        send_item(gddo_pkg::OP_ADD, 5'd1, gddo_pkg::MON_JAN, 14'd16383, 16'd0);
        send_item(gddo_pkg::OP_SUB, 5'd1, gddo_pkg::MON_JAN, 14'd10000, 16'd0);
        send_item(gddo_pkg::OP_ADD, 5'd31, gddo_pkg::MON_DEC, 14'd9999, 16'd1);
        send_item(gddo_pkg::OP_SUB, 5'd1, gddo_pkg::MON_JAN, 14'd0, 16'd1);
    endtask

    // Leap years, century years and days that do not fit their month.
    task automatic test_calendar_cases();
        send_item(gddo_pkg::OP_ADD, 5'd29, gddo_pkg::MON_FEB, 14'd1900, 16'd0);
        send_item(gddo_pkg::OP_ADD, 5'd29, gddo_pkg::MON_FEB, 14'd2000, 16'd0);
        send_item(gddo_pkg::OP_SUB, 5'd29, gddo_pkg::MON_FEB, 14'd2100, 16'd0);
        send_item(gddo_pkg::OP_ADD, 5'd28, gddo_pkg::MON_FEB, 14'd2004, 16'd1);
        send_item(gddo_pkg::OP_ADD, 5'd31, gddo_pkg::MON_FEB, 14'd2001, 16'd0);
        send_item(gddo_pkg::OP_ADD, 5'd31, gddo_pkg::MON_FEB, 14'd2000, 16'd0);
        send_item(gddo_pkg::OP_SUB, 5'd31, gddo_pkg::MON_FEB, 14'd2001, 16'd1);
        send_item(gddo_pkg::OP_ADD, 5'd0, gddo_pkg::MON_JAN, 14'd2000, 16'd0);
        send_item(gddo_pkg::OP_SUB, 5'd0, gddo_pkg::MON_APR, 14'd2001, 16'd0);
        send_item(gddo_pkg::OP_ADD, 5'd31, gddo_pkg::MON_APR, 14'd1999, 16'd0);
        send_item(gddo_pkg::OP_SUB, 5'd1, 4'd3, 14'd400, 16'd1);
    endtask

    // Random dates in bursts; most are real dates with short offsets.
    task automatic test_random_dates();
        int burst_left;
        int kind;
        logic op;
        logic [4:0] day_in;
        logic [3:0] mon_in;
        logic [13:0] year_in;
        logic [OFF_W-1:0] offset;
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
            end
            burst_left--;
            // Let everything drain once in the middle of the run.
            if (n == RANDOM_ITEMS / 2) wait_all_results();
            op   = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 15);
            if (kind < 12) begin
                mon_in  = 4'($urandom_range(gddo_pkg::MON_JAN, gddo_pkg::MON_DEC));
                year_in = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 9999))
                                                      : 14'($urandom_range(1600, 2400));
                day_in  = 5'($urandom_range(1, month_days(int'(mon_in), int'(year_in))));
            end else begin
                mon_in  = 4'($urandom_range(0, 15));
                year_in = 14'($urandom_range(0, 16383));
                day_in  = 5'($urandom_range(0, 31));
            end
            // Near the ends of the calendar a walk may run off it.
            if (kind == 11) year_in = $urandom_range(0, 1) ? 14'($urandom_range(9990, 9999))
                                                          : 14'($urandom_range(0, 9));
            case ($urandom_range(0, 15))
                0:       offset = OFF_W'($urandom());
                1, 2:    offset = OFF_W'($urandom_range(0, 4000));
                default: offset = OFF_W'($urandom_range(0, 400));
            endcase
            send_item(op, day_in, mon_in, year_in, offset);
        end
    endtask

    initial begin
        mismatch_count = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = gddo_pkg::OP_ADD;
        i_day_in       = '0;
        i_month_in     = '0;
        i_year_in      = '0;
        i_offset_days  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_offset_extremes();
        test_range_errors();
        test_calendar_cases();
        test_random_dates();

        // Let the last results come back, then let the bench settle.
        wait_all_results();
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (mismatch_count == 0 && pending_dates.size() == 0) begin
            $display("gregorian_date_day_offset_core_test passed");
        end else begin
            $display("gregorian_date_day_offset_core_test failed");
        end
        $finish;
    end

endmodule
